>>> rtl/core/pdvf_pkg.sv
package pdvf_pkg;

    localparam int CNT_W     = 24;
    localparam int SUM_W     = 25;
    localparam int INDEL_W   = 28;
    localparam int POS_W     = 28;
    localparam int TOTAL_W   = 28;
    localparam int CFG_W     = 16;
    localparam int BASE_W    = 27;
    localparam int TOT_W     = 28;
    localparam int TOT_DEL_W = 29;
    localparam int VAR_SUM_W = 30;
    localparam int X100_W    = 32;
    localparam int T33_W     = 34;
    localparam int T8_W      = 31;

    localparam int NUM_BASES = 4;

    localparam int PCT_SCALE  = 100;
    localparam int PCT_STRAND = 33;
    localparam int PCT_MIN    = 8;

    localparam int MAX_INDEL_ITEMS_DEFAULT = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_W-1:0] MIN_ALL_COVERAGE_RESET = CFG_W'(8);
    localparam logic [CFG_W-1:0] MIN_VAR_COVERAGE_RESET = CFG_W'(4);

    localparam logic REG_MIN_ALL_COVERAGE = 1'b0;
    localparam logic REG_MIN_VAR_COVERAGE = 1'b1;

    typedef enum logic [1:0] {
        KIND_REF,
        KIND_BASE,
        KIND_DEL,
        KIND_INS
    } kind_t;

    typedef struct packed {
        logic [CFG_W-1:0] min_all;
        logic [CFG_W-1:0] min_var;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0]                   position;
        logic [NUM_BASES-1:0][CNT_W-1:0]    tested_plus;
        logic [NUM_BASES-1:0][CNT_W-1:0]    tested_minus;
        logic [NUM_BASES-1:0][SUM_W-1:0]    other_sum;
        logic [1:0][SUM_W-1:0]              ref_sum;
        logic [INDEL_W-1:0]                 del_sum;
        logic [INDEL_W-1:0]                 ins_sum;
        logic [1:0]                         var_present;
        logic                               not_n;
    } snap_t;

    function automatic logic [CNT_W-1:0] sat_add24(input logic [CNT_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sat_add25(input logic [SUM_W-1:0] a,
                                                   input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    function automatic logic [INDEL_W-1:0] sat_add28(input logic [INDEL_W-1:0] a,
                                                     input logic [CNT_W-1:0] b);
        logic [INDEL_W:0] s;
        s = {1'b0, a} + (INDEL_W + 1)'(b);
        return s[INDEL_W] ? {INDEL_W{1'b1}} : s[INDEL_W-1:0];
    endfunction

endpackage

>>> rtl/core/pdvf_front.sv
module pdvf_front #(
    parameter int MAX_INDEL_ITEMS = pdvf_pkg::MAX_INDEL_ITEMS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 kind,
    input  logic                       sample,
    input  logic [1:0]                 base,
    input  logic [pdvf_pkg::CNT_W-1:0] count_plus,
    input  logic [pdvf_pkg::CNT_W-1:0] count_minus,
    input  logic                       has_variant,
    input  logic                       ref_is_n,
    input  logic [pdvf_pkg::POS_W-1:0] position,
    input  logic                       last,
    output logic                       push_valid,
    input  logic                       push_ready,
    output pdvf_pkg::snap_t            push_data
);
    import pdvf_pkg::*;

    localparam int ITEM_W = $clog2(MAX_INDEL_ITEMS + 1);

    logic [NUM_BASES-1:0][CNT_W-1:0] tp_reg, tp_next;
    logic [NUM_BASES-1:0][CNT_W-1:0] tm_reg, tm_next;
    logic [NUM_BASES-1:0][SUM_W-1:0] other_reg, other_next;
    logic [1:0][SUM_W-1:0]           ref_reg, ref_next;
    logic [INDEL_W-1:0]              del_reg, del_next;
    logic [INDEL_W-1:0]              ins_reg, ins_next;
    logic [1:0]                      var_reg, var_next;
    logic [1:0]                      ended_reg, ended_next;
    logic [1:0][ITEM_W-1:0]          items_reg, items_next;
    logic                            not_n_reg, not_n_next;
    logic                            li;
    logic                            accept;

    assign in_ready   = push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = in_valid && last;

    always_comb
    begin
        tp_next    = tp_reg;
        tm_next    = tm_reg;
        other_next = other_reg;
        ref_next   = ref_reg;
        del_next   = del_reg;
        ins_next   = ins_reg;
        var_next   = var_reg;
        ended_next = ended_reg;
        items_next = items_reg;
        not_n_next = not_n_reg;
        li         = kind[0];
        case (kind_t'(kind))
            KIND_REF:
            begin
                ref_next[sample] = sat_add25(ref_reg[sample],
                                             {1'b0, count_plus} + {1'b0, count_minus});
                if (has_variant)
                begin
                    var_next[sample] = 1'b1;
                end
                not_n_next = !ref_is_n;
            end
            KIND_BASE:
            begin
                if (sample)
                begin
                    tp_next[base] = sat_add24(tp_reg[base], count_plus);
                    tm_next[base] = sat_add24(tm_reg[base], count_minus);
                end
                else
                begin
                    other_next[base] = sat_add25(other_reg[base],
                                                 {1'b0, count_plus} + {1'b0, count_minus});
                end
            end
            KIND_DEL, KIND_INS:
            begin
                if (sample && !ended_reg[li] &&
                    items_reg[li] < ITEM_W'(MAX_INDEL_ITEMS))
                begin
                    if (count_plus == '0)
                    begin
                        ended_next[li] = 1'b1;
                    end
                    else
                    begin
                        if (li)
                        begin
                            ins_next = sat_add28(ins_reg, count_plus);
                        end
                        else
                        begin
                            del_next = sat_add28(del_reg, count_plus);
                        end
                        items_next[li] = items_reg[li] + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        push_data.position     = position;
        push_data.tested_plus  = tp_next;
        push_data.tested_minus = tm_next;
        push_data.other_sum    = other_next;
        push_data.ref_sum      = ref_next;
        push_data.del_sum      = del_next;
        push_data.ins_sum      = ins_next;
        push_data.var_present  = var_next;
        push_data.not_n        = not_n_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tp_reg    <= '0;
            tm_reg    <= '0;
            other_reg <= '0;
            ref_reg   <= '0;
            del_reg   <= '0;
            ins_reg   <= '0;
            var_reg   <= '0;
            ended_reg <= '0;
            items_reg <= '0;
            not_n_reg <= 1'b0;
        end
        else if (accept)
        begin
            not_n_reg <= not_n_next;
            if (last)
            begin
                tp_reg    <= '0;
                tm_reg    <= '0;
                other_reg <= '0;
                ref_reg   <= '0;
                del_reg   <= '0;
                ins_reg   <= '0;
                var_reg   <= '0;
                ended_reg <= '0;
                items_reg <= '0;
            end
            else
            begin
                tp_reg    <= tp_next;
                tm_reg    <= tm_next;
                other_reg <= other_next;
                ref_reg   <= ref_next;
                del_reg   <= del_next;
                ins_reg   <= ins_next;
                var_reg   <= var_next;
                ended_reg <= ended_next;
                items_reg <= items_next;
            end
        end
    end

endmodule

>>> rtl/core/pdvf_queue.sv
module pdvf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  pdvf_pkg::snap_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output pdvf_pkg::snap_t pop_data
);
    import pdvf_pkg::*;

    snap_t                  entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = count_reg != QUEUE_CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/pdvf_back.sv
module pdvf_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pdvf_pkg::cfg_t               cfg,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  pdvf_pkg::snap_t              pop_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [pdvf_pkg::POS_W-1:0]   position_res,
    output logic                         differs,
    output logic                         callable,
    output logic [pdvf_pkg::TOTAL_W-1:0] callable_total,
    output logic [pdvf_pkg::TOTAL_W-1:0] not_n_total
);
    import pdvf_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0]                position;
        logic [NUM_BASES-1:0][SUM_W-1:0] x;
        logic [NUM_BASES-1:0]            pair;
        logic [NUM_BASES-1:0]            o_zero;
        logic [BASE_W-1:0]               base_t;
        logic [BASE_W-1:0]               base_r;
        logic [SUM_W-1:0]                ref_t;
        logic [SUM_W-1:0]                ref_r;
        logic [INDEL_W-1:0]              del_sum;
        logic [INDEL_W-1:0]              ins_sum;
        logic                            var_t;
        logic                            var_r;
        logic                            not_n;
    } st1_t;

    typedef struct packed {
        logic [POS_W-1:0]                position;
        logic [NUM_BASES-1:0][SUM_W-1:0] x;
        logic [NUM_BASES-1:0]            pair;
        logic [NUM_BASES-1:0]            o_zero;
        logic [TOT_W-1:0]                tot_t;
        logic [TOT_W-1:0]                tot_r;
        logic [TOT_DEL_W-1:0]            tot_del;
        logic [VAR_SUM_W-1:0]            var_sum;
        logic                            var_t;
        logic                            var_r;
        logic                            not_n;
    } st2_t;

    typedef struct packed {
        logic [POS_W-1:0]                 position;
        logic [NUM_BASES-1:0][X100_W-1:0] x100;
        logic [NUM_BASES-1:0]             x_ge_var;
        logic [NUM_BASES-1:0]             pair;
        logic [NUM_BASES-1:0]             o_zero;
        logic [T33_W-1:0]                 t33;
        logic [T8_W-1:0]                  t8;
        logic                             ge_all_t;
        logic                             ge_all_r;
        logic                             ge_del;
        logic                             ge_var;
        logic                             r_nonzero;
        logic                             var_t;
        logic                             var_r;
        logic                             not_n;
    } st3_t;

    st1_t s1_reg, s1_next;
    st2_t s2_reg, s2_next;
    st3_t s3_reg, s3_next;
    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic take1, take2, take3, take4;

    logic [POS_W-1:0]   position_res_reg;
    logic               differs_reg, differs_next;
    logic               callable_reg, callable_next;
    logic [TOTAL_W-1:0] callable_count_reg, callable_count_next;
    logic [TOTAL_W-1:0] not_n_count_reg, not_n_count_next;
    logic [NUM_BASES-1:0] hit;

    // stall chain, back to front
    assign take4     = !out_valid_reg || out_ready;
    assign take3     = !v3_reg || take4;
    assign take2     = !v2_reg || take3;
    assign take1     = !v1_reg || take2;
    assign pop_ready = take1;

    // per-base depths and sample sums
    always_comb
    begin
        s1_next.position = pop_data.position;
        s1_next.base_t   = '0;
        s1_next.base_r   = '0;
        for (int j = 0; j < NUM_BASES; j++)
        begin
            s1_next.x[j] = {1'b0, pop_data.tested_plus[j]} + {1'b0, pop_data.tested_minus[j]};
            s1_next.pair[j] = (pop_data.tested_plus[j] > CNT_W'(1)) &&
                              (pop_data.tested_minus[j] > CNT_W'(1));
            s1_next.o_zero[j] = pop_data.other_sum[j] == '0;
            s1_next.base_t = s1_next.base_t + BASE_W'(pop_data.tested_plus[j])
                                            + BASE_W'(pop_data.tested_minus[j]);
            s1_next.base_r = s1_next.base_r + BASE_W'(pop_data.other_sum[j]);
        end
        s1_next.ref_t   = pop_data.ref_sum[1];
        s1_next.ref_r   = pop_data.ref_sum[0];
        s1_next.del_sum = pop_data.del_sum;
        s1_next.ins_sum = pop_data.ins_sum;
        s1_next.var_t   = pop_data.var_present[1];
        s1_next.var_r   = pop_data.var_present[0];
        s1_next.not_n   = pop_data.not_n;
    end

    // sample totals
    always_comb
    begin
        s2_next.position = s1_reg.position;
        s2_next.x        = s1_reg.x;
        s2_next.pair     = s1_reg.pair;
        s2_next.o_zero   = s1_reg.o_zero;
        s2_next.tot_t    = TOT_W'(s1_reg.ref_t) +
                           (s1_reg.var_t ? TOT_W'(s1_reg.base_t) : '0);
        s2_next.tot_r    = TOT_W'(s1_reg.ref_r) +
                           (s1_reg.var_r ? TOT_W'(s1_reg.base_r) : '0);
        s2_next.tot_del  = TOT_DEL_W'(s2_next.tot_t) + TOT_DEL_W'(s1_reg.del_sum);
        s2_next.var_sum  = VAR_SUM_W'(s1_reg.base_t) + VAR_SUM_W'(s1_reg.del_sum) +
                           VAR_SUM_W'(s1_reg.ins_sum);
        s2_next.var_t    = s1_reg.var_t;
        s2_next.var_r    = s1_reg.var_r;
        s2_next.not_n    = s1_reg.not_n;
    end

    // scaled terms and coverage compares
    always_comb
    begin
        s3_next.position = s2_reg.position;
        for (int j = 0; j < NUM_BASES; j++)
        begin
            s3_next.x100[j]     = X100_W'(s2_reg.x[j]) * X100_W'(PCT_SCALE);
            s3_next.x_ge_var[j] = s2_reg.x[j] >= SUM_W'(cfg.min_var);
        end
        s3_next.pair      = s2_reg.pair;
        s3_next.o_zero    = s2_reg.o_zero;
        s3_next.t33       = T33_W'(s2_reg.tot_t) * T33_W'(PCT_STRAND);
        s3_next.t8        = T8_W'(s2_reg.tot_t) * T8_W'(PCT_MIN);
        s3_next.ge_all_t  = s2_reg.tot_t >= TOT_W'(cfg.min_all);
        s3_next.ge_all_r  = s2_reg.tot_r >= TOT_W'(cfg.min_all);
        s3_next.ge_del    = s2_reg.tot_del >= TOT_DEL_W'(cfg.min_all);
        s3_next.ge_var    = s2_reg.var_sum >= VAR_SUM_W'(cfg.min_var);
        s3_next.r_nonzero = s2_reg.tot_r != '0;
        s3_next.var_t     = s2_reg.var_t;
        s3_next.var_r     = s2_reg.var_r;
        s3_next.not_n     = s2_reg.not_n;
    end

    // decision and running counts
    always_comb
    begin
        for (int j = 0; j < NUM_BASES; j++)
        begin
            hit[j] = (s3_reg.pair[j] ||
                      (s3_reg.ge_all_t && T33_W'(s3_reg.x100[j]) >= s3_reg.t33)) &&
                     s3_reg.x_ge_var[j] &&
                     s3_reg.x100[j] >= X100_W'(s3_reg.t8) &&
                     s3_reg.ge_all_r &&
                     (!s3_reg.var_r || (s3_reg.o_zero[j] && s3_reg.r_nonzero));
        end
        differs_next  = s3_reg.var_t && s3_reg.ge_del && s3_reg.ge_var && (|hit);
        callable_next = s3_reg.ge_all_t && s3_reg.ge_all_r;
        callable_count_next = callable_count_reg;
        if (callable_next && callable_count_reg != {TOTAL_W{1'b1}})
        begin
            callable_count_next = callable_count_reg + 1'b1;
        end
        not_n_count_next = not_n_count_reg;
        if (s3_reg.not_n && not_n_count_reg != {TOTAL_W{1'b1}})
        begin
            not_n_count_next = not_n_count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg             <= 1'b0;
            v2_reg             <= 1'b0;
            v3_reg             <= 1'b0;
            out_valid_reg      <= 1'b0;
            callable_count_reg <= '0;
            not_n_count_reg    <= '0;
        end
        else
        begin
            if (take1)
            begin
                v1_reg <= pop_valid;
            end
            if (take2)
            begin
                v2_reg <= v1_reg;
            end
            if (take3)
            begin
                v3_reg <= v2_reg;
            end
            if (take4)
            begin
                out_valid_reg <= v3_reg;
                if (v3_reg)
                begin
                    callable_count_reg <= callable_count_next;
                    not_n_count_reg    <= not_n_count_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take1 && pop_valid)
        begin
            s1_reg <= s1_next;
        end
        if (take2 && v1_reg)
        begin
            s2_reg <= s2_next;
        end
        if (take3 && v2_reg)
        begin
            s3_reg <= s3_next;
        end
        if (take4 && v3_reg)
        begin
            position_res_reg <= s3_reg.position;
            differs_reg      <= differs_next;
            callable_reg     <= callable_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign position_res   = position_res_reg;
    assign differs        = differs_reg;
    assign callable       = callable_reg;
    assign callable_total = callable_count_reg;
    assign not_n_total    = not_n_count_reg;

endmodule

>>> rtl/core/pileup_differential_variant_filter.sv
// Pileup differential variant filter.
// Input channel (in_valid/in_ready): one beat per count item of a genome position,
// reference-match, per-base, deletion or insertion counts for either sample; the
// beat with last set closes the position.
// Output channel (out_valid/out_ready): one beat per closed position with the
// differs and callable flags and the running callable and non-N totals.
// Configuration: cfg_write with cfg_index 0 sets min_all_coverage, index 1 sets
// min_var_coverage; write only while no position is in flight.
// Throughput: one input beat per clock while in_ready is high, the front end folding
// each accepted beat into its accumulators; decisions leave at up to one per clock.
// Path: a position's snapshot is written into the queue when its last beat is
// accepted, then passes three decision stages and the output register.
// Stall: when out_ready is low the decision pipe and a two-entry queue fill up;
// in_ready follows the queue's push_ready and drops once the queue is full, which
// holds last and non-last beats alike.
// Reset: accumulators, running totals and queue are cleared, thresholds return
// to 8 and 4.
module pileup_differential_variant_filter #(
    parameter int MAX_INDEL_ITEMS = pdvf_pkg::MAX_INDEL_ITEMS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic                         cfg_index,
    input  logic [pdvf_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   kind,
    input  logic                         sample,
    input  logic [1:0]                   base,
    input  logic [pdvf_pkg::CNT_W-1:0]   count_plus,
    input  logic [pdvf_pkg::CNT_W-1:0]   count_minus,
    input  logic                         has_variant,
    input  logic                         ref_is_n,
    input  logic [pdvf_pkg::POS_W-1:0]   position,
    input  logic                         last,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [pdvf_pkg::POS_W-1:0]   position_res,
    output logic                         differs,
    output logic                         callable,
    output logic [pdvf_pkg::TOTAL_W-1:0] callable_total,
    output logic [pdvf_pkg::TOTAL_W-1:0] not_n_total
);
    import pdvf_pkg::*;

    cfg_t  cfg_reg;
    logic  push_valid, push_ready;
    snap_t push_data;
    logic  pop_valid, pop_ready;
    snap_t pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_all <= MIN_ALL_COVERAGE_RESET;
            cfg_reg.min_var <= MIN_VAR_COVERAGE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MIN_ALL_COVERAGE: cfg_reg.min_all <= cfg_data;
                REG_MIN_VAR_COVERAGE: cfg_reg.min_var <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    pdvf_front #(
        .MAX_INDEL_ITEMS (MAX_INDEL_ITEMS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .sample      (sample),
        .base        (base),
        .count_plus  (count_plus),
        .count_minus (count_minus),
        .has_variant (has_variant),
        .ref_is_n    (ref_is_n),
        .position    (position),
        .last        (last),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    pdvf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    pdvf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_data       (pop_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .position_res   (position_res),
        .differs        (differs),
        .callable       (callable),
        .callable_total (callable_total),
        .not_n_total    (not_n_total)
    );

endmodule
